// ----- hw/rtl/spbp_pkg.sv -----
// shared constants, types and helpers for the sweep-and-prune broad phase
package spbp_pkg;

    localparam int MAX_BODIES = 32;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = IDX_W + 1;

    localparam int FIELD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = 21;
    localparam int MARGIN_W   = 17;
    localparam int KEY_W      = 37;
    localparam int ACC_W      = 41;
    localparam int PROD_W     = FIELD_W + STEP_W + 1;

    localparam int S_DATA_BITS = IDX_W + 9 * FIELD_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((IDX_W + 7) / 8) * 8;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = STEP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_COUNT = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [STEP_W-1:0]   STEP_TIME_RST = STEP_W'(1092);
    localparam logic [MARGIN_W-1:0] MARGIN_RST    = MARGIN_W'(655);

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [IDX_W-1:0]        idx_t;

    localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // clamp a wide sum to the signed key range
    function automatic key_t sat_key(input acc_t v);
        logic hi_same;
        hi_same = (&v[ACC_W-1:KEY_W-1]) | ~(|v[ACC_W-1:KEY_W-1]);
        if (hi_same) begin
            return v[KEY_W-1:0];
        end else if (v[ACC_W-1]) begin
            return KEY_MIN;
        end else begin
            return KEY_MAX;
        end
    endfunction

endpackage

// ----- hw/rtl/sweep_prune_broad_phase.sv -----
// sweep-and-prune broad phase: key builder, key store and partner scan
//
// Input stream (s_*): s_tuser selects the request, 0 loads a body, 1 queries one.
// A load carries the body index, box corners and velocity in s_tdata; it builds
// the body's low and high sort keys with one shared 41-bit adder, stepping
// multiply, two growth steps, two margin steps and two accumulations per axis,
// then one write step; it gives no result.
// A query reads the body's keys, then compares one stored body a cycle against
// them while the receiver keeps up, bounded by the single key store read port;
// a query for a body outside the count skips the scan.
// Partners come out on m_* in index order, the final one
// with m_tlast; a query with no partner gives one transfer with m_tuser low.
// s_tready is high only between requests; a finished result sits in the output
// register so the next request can be taken while it waits. When the receiver
// stalls the scan stops at the next match and holds until the register frees.
// Config (cfg_*) is always ready; the user must write it only while the block is idle, which is not enforced.
// Reset restores step time 1092, margin 655, body count 0; the key store is not
// cleared and a body must be loaded before it is queried or counted.
module sweep_prune_broad_phase (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // body_index, min_x, min_y, min_z, max_x, max_y, max_z, vel_x, vel_y, vel_z
    input  logic [spbp_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // partner_index
    output logic [spbp_pkg::M_TDATA_W-1:0]      m_tdata,
    // pair_valid
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spbp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import spbp_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_L_MUL = 4'd1;
    localparam logic [ST_W-1:0] ST_L_G1  = 4'd2;
    localparam logic [ST_W-1:0] ST_L_G2  = 4'd3;
    localparam logic [ST_W-1:0] ST_L_G3  = 4'd4;
    localparam logic [ST_W-1:0] ST_L_G4  = 4'd5;
    localparam logic [ST_W-1:0] ST_L_AL  = 4'd6;
    localparam logic [ST_W-1:0] ST_L_AH  = 4'd7;
    localparam logic [ST_W-1:0] ST_L_WR  = 4'd8;
    localparam logic [ST_W-1:0] ST_Q_RD  = 4'd9;
    localparam logic [ST_W-1:0] ST_Q_CAP = 4'd10;
    localparam logic [ST_W-1:0] ST_Q_SCN = 4'd11;
    localparam logic [ST_W-1:0] ST_Q_FIN = 4'd12;

    localparam int S_W   = PROD_W - FRAC_W;
    localparam int AXIS_W = 2;
    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(2);

    // configuration
    logic [STEP_W-1:0]   step_time_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [CNT_W-1:0]    body_count_reg;
    logic [CNT_W-1:0]    cnt;

    // key store
    key_t key_low_mem  [MAX_BODIES];
    key_t key_high_mem [MAX_BODIES];
    key_t rd_lo_reg, rd_hi_reg;
    idx_t rd_addr;

    // control
    logic [ST_W-1:0]   state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    idx_t              a_reg;

    // load datapath
    logic signed [FIELD_W-1:0] in_lo_reg  [3];
    logic signed [FIELD_W-1:0] in_hi_reg  [3];
    logic signed [FIELD_W-1:0] in_vel_reg [3];
    logic signed [FIELD_W-1:0] lo_sel, hi_sel, vel_sel;
    logic signed [PROD_W-1:0]  prod_reg;
    acc_t lo_reg, lo_next, hi_reg, hi_next;
    acc_t slo_reg, slo_next, shi_reg, shi_next;
    acc_t step_s, margin_ext;
    acc_t op_a, op_b, add_sum;
    logic add_sub;

    // query datapath
    key_t             alo_reg, ahi_reg;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_v_reg, cmp_v_next;
    idx_t             cmp_idx_reg, cmp_idx_next;
    logic             pend_v_reg, pend_v_next;
    idx_t             pend_idx_reg, pend_idx_next;
    logic             match, after_a, before_a, scan_done, advance;

    // output register
    logic m_tvalid_reg, m_tvalid_next;
    idx_t m_idx_reg, m_idx_next;
    logic m_pv_reg, m_pv_next;
    logic m_last_reg, m_last_next;
    logic out_free;

    logic s_xfer;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W-IDX_W){1'b0}}, m_idx_reg};
    assign m_tuser   = m_pv_reg;
    assign m_tlast   = m_last_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cnt = (body_count_reg > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : body_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg  <= STEP_TIME_RST;
            margin_reg     <= MARGIN_RST;
            body_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_STEP_TIME:  step_time_reg  <= cfg_data;
                CFG_MARGIN:     margin_reg     <= cfg_data[MARGIN_W-1:0];
                CFG_BODY_COUNT: body_count_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // axis operand selection
    always_comb begin
        unique case (axis_reg)
            2'd0: begin
                lo_sel = in_lo_reg[0]; hi_sel = in_hi_reg[0]; vel_sel = in_vel_reg[0];
            end
            2'd1: begin
                lo_sel = in_lo_reg[1]; hi_sel = in_hi_reg[1]; vel_sel = in_vel_reg[1];
            end
            default: begin
                lo_sel = in_lo_reg[2]; hi_sel = in_hi_reg[2]; vel_sel = in_vel_reg[2];
            end
        endcase
    end

    // floor of v*dt in q16.16 is the arithmetic shift of the product
    assign step_s     = {{(ACC_W-S_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:FRAC_W]};
    assign margin_ext = {{(ACC_W-MARGIN_W){1'b0}}, margin_reg};

    // the shared adder
    always_comb begin
        op_a    = '0;
        op_b    = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_L_G1: begin op_a = lo_reg;  op_b = step_s; end
            ST_L_G2: begin op_a = hi_reg;  op_b = step_s; end
            ST_L_G3: begin op_a = lo_reg;  op_b = margin_ext; add_sub = 1'b1; end
            ST_L_G4: begin op_a = hi_reg;  op_b = margin_ext; end
            ST_L_AL: begin op_a = slo_reg; op_b = lo_reg; end
            ST_L_AH: begin op_a = shi_reg; op_b = hi_reg; end
            default: ;
        endcase
    end
    assign add_sum = op_a + (op_b ^ {ACC_W{add_sub}}) + {{(ACC_W-1){1'b0}}, add_sub};

    // partner test, ties ordered by body index
    assign after_a  = (rd_lo_reg > alo_reg) || (rd_lo_reg == alo_reg && cmp_idx_reg > a_reg);
    assign before_a = (rd_lo_reg < ahi_reg) || (rd_lo_reg == ahi_reg && cmp_idx_reg < a_reg);
    assign match    = cmp_v_reg && (cmp_idx_reg != a_reg) && after_a && before_a;
    assign scan_done = (scan_idx_reg == cnt);
    // a second match needs the output register to push the older one out
    assign advance  = !(match && pend_v_reg && !out_free);

    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        slo_next       = slo_reg;
        shi_next       = shi_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_v_next     = cmp_v_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_v_next    = pend_v_reg;
        pend_idx_next  = pend_idx_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_idx_next     = m_idx_reg;
        m_pv_next      = m_pv_reg;
        m_last_next    = m_last_reg;
        rd_addr        = a_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser[0] == REQ_LOAD) begin
                        axis_next  = '0;
                        slo_next   = '0;
                        shi_next   = '0;
                        state_next = ST_L_MUL;
                    end else if ({1'b0, s_tdata[IDX_W-1:0]} >= cnt) begin
                        pend_v_next = 1'b0;
                        state_next  = ST_Q_FIN;
                    end else begin
                        state_next = ST_Q_RD;
                    end
                end
            end
            ST_L_MUL: begin
                lo_next    = {{(ACC_W-FIELD_W){lo_sel[FIELD_W-1]}}, lo_sel};
                hi_next    = {{(ACC_W-FIELD_W){hi_sel[FIELD_W-1]}}, hi_sel};
                state_next = ST_L_G1;
            end
            ST_L_G1, ST_L_G2: begin
                if (add_sum < lo_reg) begin
                    lo_next = add_sum;
                end
                if (add_sum > hi_reg) begin
                    hi_next = add_sum;
                end
                state_next = (state_reg == ST_L_G1) ? ST_L_G2 : ST_L_G3;
            end
            ST_L_G3: begin
                lo_next    = add_sum;
                state_next = ST_L_G4;
            end
            ST_L_G4: begin
                hi_next    = add_sum;
                state_next = ST_L_AL;
            end
            ST_L_AL: begin
                slo_next   = add_sum;
                state_next = ST_L_AH;
            end
            ST_L_AH: begin
                shi_next = add_sum;
                if (axis_reg == AXIS_LAST) begin
                    state_next = ST_L_WR;
                end else begin
                    axis_next  = axis_reg + AXIS_W'(1);
                    state_next = ST_L_MUL;
                end
            end
            ST_L_WR: begin
                state_next = ST_IDLE;
            end
            ST_Q_RD: begin
                state_next = ST_Q_CAP;
            end
            ST_Q_CAP: begin
                scan_idx_next = '0;
                cmp_v_next    = 1'b0;
                pend_v_next   = 1'b0;
                state_next    = ST_Q_SCN;
            end
            ST_Q_SCN: begin
                rd_addr = advance ? scan_idx_reg[IDX_W-1:0] : cmp_idx_reg;
                if (advance) begin
                    cmp_v_next   = !scan_done;
                    cmp_idx_next = scan_idx_reg[IDX_W-1:0];
                    if (!scan_done) begin
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end
                    if (match) begin
                        if (pend_v_reg) begin
                            m_tvalid_next = 1'b1;
                            m_idx_next    = pend_idx_reg;
                            m_pv_next     = 1'b1;
                            m_last_next   = 1'b0;
                        end
                        pend_v_next   = 1'b1;
                        pend_idx_next = cmp_idx_reg;
                    end
                    if (scan_done) begin
                        state_next = ST_Q_FIN;
                    end
                end
            end
            ST_Q_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_idx_next    = pend_v_reg ? pend_idx_reg : '0;
                    m_pv_next     = pend_v_reg;
                    m_last_next   = 1'b1;
                    pend_v_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cmp_v_reg    <= 1'b0;
            pend_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmp_v_reg    <= cmp_v_next;
            pend_v_reg   <= pend_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        axis_reg     <= axis_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        slo_reg      <= slo_next;
        shi_reg      <= shi_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        pend_idx_reg <= pend_idx_next;
        m_idx_reg    <= m_idx_next;
        m_pv_reg     <= m_pv_next;
        m_last_reg   <= m_last_next;
        if (state_reg == ST_L_MUL) begin
            prod_reg <= vel_sel * $signed({1'b0, step_time_reg});
        end
        if (state_reg == ST_Q_CAP) begin
            alo_reg <= rd_lo_reg;
            ahi_reg <= rd_hi_reg;
        end
        if (s_xfer) begin
            a_reg         <= s_tdata[IDX_W-1:0];
            in_lo_reg[0]  <= s_tdata[IDX_W + 0*FIELD_W +: FIELD_W];
            in_lo_reg[1]  <= s_tdata[IDX_W + 1*FIELD_W +: FIELD_W];
            in_lo_reg[2]  <= s_tdata[IDX_W + 2*FIELD_W +: FIELD_W];
            in_hi_reg[0]  <= s_tdata[IDX_W + 3*FIELD_W +: FIELD_W];
            in_hi_reg[1]  <= s_tdata[IDX_W + 4*FIELD_W +: FIELD_W];
            in_hi_reg[2]  <= s_tdata[IDX_W + 5*FIELD_W +: FIELD_W];
            in_vel_reg[0] <= s_tdata[IDX_W + 6*FIELD_W +: FIELD_W];
            in_vel_reg[1] <= s_tdata[IDX_W + 7*FIELD_W +: FIELD_W];
            in_vel_reg[2] <= s_tdata[IDX_W + 8*FIELD_W +: FIELD_W];
        end
    end

    // key store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_L_WR) begin
            key_low_mem[a_reg]  <= sat_key(slo_reg);
            key_high_mem[a_reg] <= sat_key(shi_reg);
        end
        rd_lo_reg <= key_low_mem[rd_addr];
        rd_hi_reg <= key_high_mem[rd_addr];
    end

    // a transfer without a partner always closes its query
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty result without last flag");

    // a held partner only exists while a query is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_v_reg |-> (state_reg == ST_Q_SCN || state_reg == ST_Q_FIN))
        else $error("pending partner outside a query");

    // the compare stage never holds a body outside the taking-part range
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_v_reg |-> ({1'b0, cmp_idx_reg} < cnt))
        else $error("compare stage beyond body count");

    // a taken request leaves the block busy, with s_tready low after it
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken twice in a row");

endmodule
